[hw/rtl/ffba_pkg.sv]
// Shared constants and status codes for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

	// Default table depth and address width.
	localparam int DEF_MAX_BLOCKS = 32;
	localparam int DEF_ADDR_BITS  = 16;

	// Widths fixed by the interface.
	localparam int SIZE_W   = 17;
	localparam int STATUS_W = 3;

	// Pool size after reset, before clamping to the address range.
	localparam logic [SIZE_W-1:0] POOL_RESET = 17'd65536;

	// Request codes.
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

endpackage

[hw/rtl/ffba_table.sv]
// Block table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ffba_table #(
	parameter int DEPTH = ffba_pkg::DEF_MAX_BLOCKS,
	parameter int WIDTH = 34
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Synchronous write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Synchronous read; the read data is registered.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/ffba_ctrl.sv]
// Allocator sequencer: table scan, entry shifting, split and merge write-back.
`timescale 1ns / 1ps

module ffba_ctrl #(
	parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
	parameter int ADDR_BITS  = ffba_pkg::DEF_ADDR_BITS,
	localparam int IDX_W = $clog2(MAX_BLOCKS),
	localparam int ENT_W = 2 * ADDR_BITS + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [ffba_pkg::SIZE_W-1:0]   request_size,
	input  logic [ADDR_BITS-1:0]          address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffba_pkg::STATUS_W-1:0] status,
	output logic [ADDR_BITS-1:0]          granted_address,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ffba_pkg::SIZE_W-1:0]   pool_length,
	output logic                          mem_we,
	output logic [IDX_W-1:0]              mem_waddr,
	output logic [ENT_W-1:0]              mem_wdata,
	output logic [IDX_W-1:0]              mem_raddr,
	input  logic [ENT_W-1:0]              mem_rdata
);

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int LEN_W = ADDR_BITS + 1;
	localparam int CMP_W = (LEN_W > ffba_pkg::SIZE_W) ? LEN_W : ffba_pkg::SIZE_W;
	localparam logic [CMP_W-1:0] POOL_MAX = {{(CMP_W-1){1'b0}}, 1'b1} << ADDR_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BLOCKS);

	typedef struct packed {
		logic                 used;
		logic [LEN_W-1:0]     len;
		logic [ADDR_BITS-1:0] off;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SCAN, S_NRD, S_NEV, S_SHIFT, S_WRA, S_WRB, S_DONE
	} state_t;

	// Clamp a written pool size to the range 1 .. 2^ADDR_BITS.
	function automatic logic [LEN_W-1:0] clamp_pool(input logic [ffba_pkg::SIZE_W-1:0] v);
		logic [CMP_W-1:0] x;
		x = CMP_W'(v);
		if (x == '0) begin
			x = CMP_W'(1);
		end else if (x > POOL_MAX) begin
			x = POOL_MAX;
		end
		return x[LEN_W-1:0];
	endfunction

	state_t                        state_q;
	logic [LEN_W-1:0]              pool_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          op_q;
	logic [ffba_pkg::SIZE_W-1:0]   size_q;
	logic [ADDR_BITS-1:0]          addr_q;
	logic [CNT_W-1:0]              rd_idx_q;
	logic                          chk_v_s1;
	logic [CNT_W-1:0]              chk_idx_s1;
	logic [CNT_W-1:0]              hit_idx_q;
	entry_t                        hit_q;
	entry_t                        prev_q;
	logic                          sh_up_q;
	logic [CNT_W-1:0]              sh_rd_q;
	logic [CNT_W-1:0]              sh_n_q;
	logic [1:0]                    sh_dist_q;
	logic                          sh_pend_s1;
	logic [CNT_W-1:0]              sh_dst_s1;
	logic [CNT_W-1:0]              wa_idx_q;
	entry_t                        wa_ent_q;
	logic [CNT_W-1:0]              wb_idx_q;
	entry_t                        wb_ent_q;
	logic [ffba_pkg::STATUS_W-1:0] res_st_q;
	logic [ADDR_BITS-1:0]          res_ga_q;
	logic                          out_v_q;
	logic [ffba_pkg::STATUS_W-1:0] out_st_q;
	logic [ADDR_BITS-1:0]          out_ga_q;

	entry_t                        rd_ent;
	logic                          match;
	logic [CNT_W-1:0]              hit_nx;
	logic                          has_next;
	logic                          mrg_prev;
	logic                          mrg_next;
	logic [LEN_W-1:0]              mrg_len;
	logic [CMP_W-1:0]              rem_len;
	entry_t                        wr_ent;

	assign rd_ent = entry_t'(mem_rdata);

	// Handshake outputs.
	assign in_ready        = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready       = (state_q == S_IDLE);
	assign out_valid       = out_v_q;
	assign status          = out_st_q;
	assign granted_address = out_ga_q;

	// Scan test: first free block that fits, or the used block starting at the address.
	always_comb begin
		if (op_q == ffba_pkg::ACT_FREE) begin
			match = rd_ent.used && (rd_ent.off == addr_q);
		end else begin
			match = !rd_ent.used && (CMP_W'(rd_ent.len) >= CMP_W'(size_q));
		end
		rem_len = CMP_W'(rd_ent.len) - CMP_W'(size_q);
	end

	// Neighbor merge decision for a free, evaluated when the next entry arrives.
	always_comb begin
		hit_nx   = hit_idx_q + CNT_W'(1);
		has_next = hit_nx < cnt_q;
		mrg_prev = (hit_idx_q != '0) && !prev_q.used &&
			(LEN_W'(prev_q.off) + prev_q.len == LEN_W'(hit_q.off));
		mrg_next = has_next && !rd_ent.used &&
			(LEN_W'(hit_q.off) + hit_q.len == LEN_W'(rd_ent.off));
		mrg_len  = hit_q.len + (mrg_prev ? prev_q.len : '0) + (mrg_next ? rd_ent.len : '0);
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		wr_ent    = '0;
		mem_raddr = '0;
		unique case (state_q)
			S_INIT: begin
				mem_we     = 1'b1;
				wr_ent.len = pool_q;
			end
			S_SCAN: begin
				mem_raddr = rd_idx_q[IDX_W-1:0];
			end
			S_NRD: begin
				mem_raddr = hit_nx[IDX_W-1:0];
			end
			S_SHIFT: begin
				mem_raddr = sh_rd_q[IDX_W-1:0];
				if (sh_pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = sh_dst_s1[IDX_W-1:0];
					wr_ent    = rd_ent;
				end
			end
			S_WRA: begin
				mem_we    = 1'b1;
				mem_waddr = wa_idx_q[IDX_W-1:0];
				wr_ent    = wa_ent_q;
			end
			S_WRB: begin
				mem_we    = 1'b1;
				mem_waddr = wb_idx_q[IDX_W-1:0];
				wr_ent    = wb_ent_q;
			end
			default: begin
			end
		endcase
		mem_wdata = wr_ent;
	end

	// Sequencer: state and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			pool_q     <= clamp_pool(ffba_pkg::POOL_RESET);
			cnt_q      <= CNT_W'(1);
			chk_v_s1   <= 1'b0;
			sh_pend_s1 <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			// A result transfer empties the output register unless a new result loads it.
			if (out_v_q && out_ready && state_q != S_DONE) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cfg_valid) begin
						pool_q  <= clamp_pool(pool_length);
						cnt_q   <= CNT_W'(1);
						state_q <= S_INIT;
					end else if (in_valid) begin
						op_q     <= action;
						size_q   <= request_size;
						addr_q   <= address;
						rd_idx_q <= '0;
						chk_v_s1 <= 1'b0;
						if (action == ffba_pkg::ACT_ALLOC && request_size == '0) begin
							res_st_q <= ffba_pkg::ST_ZERO;
							res_ga_q <= '0;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (chk_v_s1 && match) begin
						chk_v_s1  <= 1'b0;
						hit_idx_q <= chk_idx_s1;
						hit_q     <= rd_ent;
						if (op_q == ffba_pkg::ACT_FREE) begin
							state_q <= S_NRD;
						end else if (CMP_W'(rd_ent.len) == CMP_W'(size_q)) begin
							wb_idx_q <= chk_idx_s1;
							wb_ent_q <= '{used: 1'b1, len: rd_ent.len, off: rd_ent.off};
							res_st_q <= ffba_pkg::ST_OK;
							res_ga_q <= rd_ent.off;
							state_q  <= S_WRB;
						end else if (cnt_q == CNT_MAX) begin
							res_st_q <= ffba_pkg::ST_FULL;
							res_ga_q <= '0;
							state_q  <= S_DONE;
						end else begin
							// Split: open a slot after the block, then write both halves.
							wa_idx_q  <= chk_idx_s1 + CNT_W'(1);
							wa_ent_q  <= '{used: 1'b0, len: rem_len[LEN_W-1:0],
								off: rd_ent.off + ADDR_BITS'(size_q)};
							wb_idx_q  <= chk_idx_s1;
							wb_ent_q  <= '{used: 1'b1, len: LEN_W'(size_q), off: rd_ent.off};
							res_st_q  <= ffba_pkg::ST_OK;
							res_ga_q  <= rd_ent.off;
							sh_up_q   <= 1'b1;
							sh_rd_q   <= cnt_q - CNT_W'(1);
							sh_n_q    <= cnt_q - CNT_W'(1) - chk_idx_s1;
							sh_dist_q <= 2'd1;
							cnt_q     <= cnt_q + CNT_W'(1);
							state_q   <= S_SHIFT;
						end
					end else if (chk_v_s1 && chk_idx_s1 == cnt_q - CNT_W'(1)) begin
						chk_v_s1 <= 1'b0;
						res_st_q <= (op_q == ffba_pkg::ACT_FREE) ? ffba_pkg::ST_UNKNOWN
							: ffba_pkg::ST_NOFIT;
						res_ga_q <= '0;
						state_q  <= S_DONE;
					end else begin
						if (chk_v_s1) begin
							prev_q <= rd_ent;
						end
						if (rd_idx_q < cnt_q) begin
							chk_v_s1   <= 1'b1;
							chk_idx_s1 <= rd_idx_q;
							rd_idx_q   <= rd_idx_q + CNT_W'(1);
						end else begin
							chk_v_s1 <= 1'b0;
						end
					end
				end
				S_NRD: begin
					state_q <= S_NEV;
				end
				S_NEV: begin
					// Close the gap left by merged neighbors, then write the merged block.
					wb_idx_q  <= mrg_prev ? hit_idx_q - CNT_W'(1) : hit_idx_q;
					wb_ent_q  <= '{used: 1'b0, len: mrg_len,
						off: mrg_prev ? prev_q.off : hit_q.off};
					res_st_q  <= ffba_pkg::ST_OK;
					res_ga_q  <= '0;
					sh_up_q   <= 1'b0;
					sh_rd_q   <= hit_nx + CNT_W'(mrg_next);
					sh_n_q    <= cnt_q - hit_nx - CNT_W'(mrg_next);
					sh_dist_q <= 2'(mrg_prev) + 2'(mrg_next);
					cnt_q     <= cnt_q - CNT_W'(mrg_prev) - CNT_W'(mrg_next);
					state_q   <= S_SHIFT;
				end
				S_SHIFT: begin
					if (sh_n_q != '0) begin
						sh_pend_s1 <= 1'b1;
						sh_dst_s1  <= sh_up_q ? sh_rd_q + CNT_W'(1) : sh_rd_q - CNT_W'(sh_dist_q);
						sh_rd_q    <= sh_up_q ? sh_rd_q - CNT_W'(1) : sh_rd_q + CNT_W'(1);
						sh_n_q     <= sh_n_q - CNT_W'(1);
					end else begin
						sh_pend_s1 <= 1'b0;
						if (!sh_pend_s1) begin
							state_q <= sh_up_q ? S_WRA : S_WRB;
						end
					end
				end
				S_WRA: begin
					state_q <= S_WRB;
				end
				S_WRB: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_v_q || out_ready) begin
						out_v_q  <= 1'b1;
						out_st_q <= res_st_q;
						out_ga_q <= res_ga_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// The table always holds between one and MAX_BLOCKS blocks.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= CNT_MAX))
		else $error("block count out of range");

	// Only a successful allocate reports a nonzero address.
	a_ga_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (out_st_q != ffba_pkg::ST_OK) |-> (out_ga_q == '0))
		else $error("address reported with failing status");

	// A configuration transfer rebuilds the table before any new request.
	a_cfg_init: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> (state_q == S_INIT) && (cnt_q == CNT_W'(1)))
		else $error("table not rebuilt after configuration");

	// While the shift still has entries to read, the entry being written is never the one being read.
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) && mem_we && (sh_n_q != '0) |-> (mem_waddr != mem_raddr))
		else $error("shift write collides with shift read");
`endif

endmodule

[hw/rtl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator with free-block coalescing.
`timescale 1ns / 1ps

// The pool is kept as an address-ordered table of up to MAX_BLOCKS blocks in one
// synchronous memory, and requests are handled one at a time. An allocate scans
// the table from entry 0, one entry per cycle, until the first free block that
// fits; a free scans likewise for the used block starting at the address. A miss
// scans every entry of the table before its result. A split moves the entries
// behind the block up by one slot and a merge moves them down over the absorbed
// neighbors, one entry at a time. A free first reads the entry after the block to
// decide the merge and, after the move, writes the merged free block; a split
// writes the free remainder and then the used block; an exact fit only marks its
// block used. The entries scanned and the entries moved never add up to more than
// the table. A finished result waits in an output register while the next request
// is taken. After reset and after each pool_length write, the table is rebuilt as
// one free block.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
	parameter int ADDR_BITS  = ffba_pkg::DEF_ADDR_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [ffba_pkg::SIZE_W-1:0]   request_size,
	input  logic [ADDR_BITS-1:0]          address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ffba_pkg::STATUS_W-1:0] status,
	output logic [ADDR_BITS-1:0]          granted_address,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ffba_pkg::SIZE_W-1:0]   pool_length
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int ENT_W = 2 * ADDR_BITS + 2;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [ENT_W-1:0] mem_rdata;

	// Request sequencer.
	ffba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ADDR_BITS  (ADDR_BITS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.request_size    (request_size),
		.address         (address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.granted_address (granted_address),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.pool_length     (pool_length),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.mem_raddr       (mem_raddr),
		.mem_rdata       (mem_rdata)
	);

	// Block table storage.
	ffba_table #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (ENT_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
